// ===== sv/hsmm_pkg.sv =====
`timescale 1ns / 1ps

package hsmm_pkg;

  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned POLL_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_POLLS = 2'd1;

  localparam logic [DELAY_W-1:0] DELAY_TICKS_RST   = 16'd10;
  localparam logic [POLL_W-1:0]  TIMEOUT_POLLS_RST = 17'd67000;

  localparam logic [3:0] RESET_PULSES = 4'd9;
  localparam logic [3:0] BYTE_BITS    = 4'd8;

  localparam logic [7:0] CMD_TEMP  = 8'h03;
  localparam logic [7:0] CMD_HUMID = 8'h05;

  typedef struct packed {
    logic start_req;
    logic mode;
    logic sda_in;
  } hsmm_in_t;

  typedef struct packed {
    logic        scl;
    logic        sda_oe;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] value;
    logic [7:0]  checksum;
  } hsmm_out_t;

endpackage

// ===== sv/humidity_sensor_measure_master_top.sv =====
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while in_ready is high; each request is one tick of the bus sequencer.
// in_ready is high while the output register is empty or its result is taken that cycle.
// Reset (rst_n low, synchronous): sequencer idle, counters and results zero,
// delay_ticks 10, timeout_polls 67000, no result pending.
`timescale 1ns / 1ps

module humidity_sensor_measure_master_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hsmm_pkg::hsmm_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hsmm_pkg::hsmm_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsmm_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import hsmm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CR_A, PH_CR_B, PH_CR_H, PH_CR_L,
    PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6, PH_TS7, PH_TS8,
    PH_WB_D, PH_WB_H, PH_WB_L, PH_WB_R, PH_WB_A, PH_POLL,
    PH_RD_REL, PH_RD_H, PH_RD_L, PH_RD_AK, PH_RD_AH, PH_RD_AL, PH_RD_FIN,
    PH_DONE, PH_DONE_TO
  } phase_t;

  logic [DELAY_W-1:0] delay_ticks_r;
  logic [POLL_W-1:0]  timeout_polls_r;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         step_count_r, step_count_nxt;
  logic [DELAY_W-1:0] delay_count_r, delay_count_nxt;
  logic [POLL_W-1:0]  poll_count_r, poll_count_nxt;
  logic [7:0]         shift_byte_r, shift_byte_nxt;
  logic [15:0]        result_value_r, result_value_nxt;
  logic [7:0]         result_check_r, result_check_nxt;
  logic               kind_held_r, kind_held_nxt;

  hsmm_out_t          out_r, out_nxt;
  logic               out_valid_r;

  logic               accept;
  logic [DELAY_W-1:0] eff_delay;
  logic               delay_more;
  logic [3:0]         step_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign eff_delay  = (delay_ticks_r == '0) ? DELAY_W'(1) : delay_ticks_r;
  assign delay_more = ({1'b0, delay_count_r} + 17'd1) < {1'b0, eff_delay};
  assign step_inc   = step_count_r + 4'd1;

  always_comb begin
    phase_nxt        = phase_r;
    step_count_nxt   = step_count_r;
    delay_count_nxt  = delay_count_r;
    poll_count_nxt   = poll_count_r;
    shift_byte_nxt   = shift_byte_r;
    result_value_nxt = result_value_r;
    result_check_nxt = result_check_r;
    kind_held_nxt    = kind_held_r;
    if (phase_r == PH_IDLE) begin
      if (in_data.start_req) begin
        kind_held_nxt   = in_data.mode;
        step_count_nxt  = '0;
        delay_count_nxt = '0;
        poll_count_nxt  = '0;
        phase_nxt       = PH_CR_A;
      end
    end else if (phase_r == PH_DONE || phase_r == PH_DONE_TO) begin
      phase_nxt = PH_IDLE;
    end else if (phase_r == PH_POLL) begin
      if (!in_data.sda_in) begin
        poll_count_nxt  = '0;
        step_count_nxt  = '0;
        delay_count_nxt = '0;
        phase_nxt       = PH_RD_REL;
      end else if (poll_count_r >= timeout_polls_r) begin
        phase_nxt = PH_DONE_TO;
      end else begin
        poll_count_nxt = poll_count_r + POLL_W'(1);
      end
    end else if (delay_more) begin
      delay_count_nxt = delay_count_r + DELAY_W'(1);
    end else begin
      delay_count_nxt = '0;
      unique case (phase_r)
        PH_CR_L: begin
          if (step_inc >= RESET_PULSES) begin
            step_count_nxt = '0;
            phase_nxt      = PH_TS1;
          end else begin
            step_count_nxt = step_inc;
            phase_nxt      = PH_CR_H;
          end
        end
        PH_TS8: begin
          shift_byte_nxt = kind_held_r ? CMD_HUMID : CMD_TEMP;
          step_count_nxt = '0;
          phase_nxt      = PH_WB_D;
        end
        PH_WB_L: begin
          shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
          step_count_nxt = step_inc;
          phase_nxt      = (step_inc >= BYTE_BITS) ? PH_WB_R : PH_WB_D;
        end
        PH_WB_A: begin
          poll_count_nxt = '0;
          phase_nxt      = PH_POLL;
        end
        PH_RD_REL: begin
          step_count_nxt = '0;
          phase_nxt      = PH_RD_H;
        end
        PH_RD_H: begin
          shift_byte_nxt = {shift_byte_r[6:0], in_data.sda_in};
          phase_nxt      = PH_RD_L;
        end
        PH_RD_L: begin
          step_count_nxt = step_inc;
          if (step_inc >= BYTE_BITS) begin
            if (poll_count_r == '0) begin
              result_value_nxt[15:8] = shift_byte_r;
            end else if (poll_count_r == POLL_W'(1)) begin
              result_value_nxt[7:0] = shift_byte_r;
            end else begin
              result_check_nxt = shift_byte_r;
            end
            phase_nxt = PH_RD_AK;
          end else begin
            phase_nxt = PH_RD_H;
          end
        end
        PH_RD_FIN: begin
          poll_count_nxt = poll_count_r + POLL_W'(1);
          phase_nxt = ((poll_count_r + POLL_W'(1)) >= POLL_W'(3)) ? PH_DONE : PH_RD_REL;
        end
        PH_CR_B:  phase_nxt = PH_CR_H;
        PH_CR_H:  phase_nxt = PH_CR_L;
        PH_CR_A:  phase_nxt = PH_CR_B;
        PH_TS1:   phase_nxt = PH_TS2;
        PH_TS2:   phase_nxt = PH_TS3;
        PH_TS3:   phase_nxt = PH_TS4;
        PH_TS4:   phase_nxt = PH_TS5;
        PH_TS5:   phase_nxt = PH_TS6;
        PH_TS6:   phase_nxt = PH_TS7;
        PH_TS7:   phase_nxt = PH_TS8;
        PH_WB_D:  phase_nxt = PH_WB_H;
        PH_WB_H:  phase_nxt = PH_WB_L;
        PH_WB_R:  phase_nxt = PH_WB_A;
        PH_RD_AK: phase_nxt = PH_RD_AH;
        PH_RD_AH: phase_nxt = PH_RD_AL;
        PH_RD_AL: phase_nxt = PH_RD_FIN;
        default:  phase_nxt = phase_r;
      endcase
    end
  end

  // line levels and result fields follow the state after this tick
  always_comb begin
    logic bit_out;
    logic ack_out;
    logic done;
    bit_out = shift_byte_nxt[7];
    ack_out = (poll_count_nxt >= POLL_W'(2));
    done    = (phase_nxt == PH_DONE) || (phase_nxt == PH_DONE_TO);
    out_nxt = '0;
    out_nxt.sda_oe  = 1'b1;
    out_nxt.sda_out = 1'b1;
    unique case (phase_nxt)
      PH_CR_A, PH_CR_B, PH_CR_L, PH_TS1, PH_TS2, PH_TS8, PH_RD_FIN: ;
      PH_CR_H, PH_TS3, PH_TS7: out_nxt.scl = 1'b1;
      PH_TS4, PH_TS6: begin
        out_nxt.scl     = 1'b1;
        out_nxt.sda_out = 1'b0;
      end
      PH_TS5: out_nxt.sda_out = 1'b0;
      PH_WB_D, PH_WB_L: out_nxt.sda_out = bit_out;
      PH_WB_H: begin
        out_nxt.scl     = 1'b1;
        out_nxt.sda_out = bit_out;
      end
      PH_WB_A, PH_RD_H: begin
        out_nxt.scl    = 1'b1;
        out_nxt.sda_oe = 1'b0;
      end
      PH_RD_REL: out_nxt.sda_oe = (poll_count_nxt != '0);
      PH_RD_AK, PH_RD_AL: out_nxt.sda_out = ack_out;
      PH_RD_AH: begin
        out_nxt.scl     = 1'b1;
        out_nxt.sda_out = ack_out;
      end
      default: out_nxt.sda_oe = 1'b0;
    endcase
    out_nxt.busy_res  = (phase_nxt != PH_IDLE) && !done;
    out_nxt.done_res  = done;
    out_nxt.timed_out = (phase_nxt == PH_DONE_TO);
    out_nxt.value     = (phase_nxt == PH_DONE) ? result_value_nxt : '0;
    out_nxt.checksum  = (phase_nxt == PH_DONE) ? result_check_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r   <= DELAY_TICKS_RST;
      timeout_polls_r <= TIMEOUT_POLLS_RST;
      phase_r         <= PH_IDLE;
      step_count_r    <= '0;
      delay_count_r   <= '0;
      poll_count_r    <= '0;
      shift_byte_r    <= '0;
      result_value_r  <= '0;
      result_check_r  <= '0;
      kind_held_r     <= 1'b0;
      out_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DELAY_TICKS:   delay_ticks_r   <= cfg_data[DELAY_W-1:0];
          CFG_TIMEOUT_POLLS: timeout_polls_r <= cfg_data[POLL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_r        <= phase_nxt;
        step_count_r   <= step_count_nxt;
        delay_count_r  <= delay_count_nxt;
        poll_count_r   <= poll_count_nxt;
        shift_byte_r   <= shift_byte_nxt;
        result_value_r <= result_value_nxt;
        result_check_r <= result_check_nxt;
        kind_held_r    <= kind_held_nxt;
        out_r          <= out_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == PH_DONE || phase_r == PH_DONE_TO) |=> phase_r == PH_IDLE)
    else $error("sequencer did not return to idle after done");

  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.busy_res && !out_r.scl && !out_r.sda_oe)
    else $error("done result with bus still active");

  a_timeout_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.timed_out |->
      out_r.done_res && out_r.value == '0 && out_r.checksum == '0)
    else $error("timed-out result carries data");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hsmm_pkg::*;

  localparam int READ_BYTES        = 3;
  localparam int RANDOM_ITEMS      = 350;
  localparam int RESET_PROBE_TICKS = 45;
  localparam int LONG_HOLD         = 300;
  localparam int WATCHDOG_LIMIT    = 5000;
  localparam int MAX_REPORTS       = 40;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RST_A, ST_RST_B, ST_RST_HI, ST_RST_LO,
    ST_TS1, ST_TS2, ST_TS3, ST_TS4, ST_TS5, ST_TS6, ST_TS7, ST_TS8,
    ST_CMD_SET, ST_CMD_HI, ST_CMD_LO, ST_CMD_REL, ST_CMD_ACK, ST_WAIT,
    ST_RX_REL, ST_RX_HI, ST_RX_LO, ST_ACK_SET, ST_ACK_HI, ST_ACK_LO, ST_RX_END,
    ST_DONE, ST_DONE_TO
  } seq_st_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  hsmm_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  hsmm_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // sequencer model
  seq_st_e             bus_st;
  logic [3:0]          bit_cnt;
  logic [DELAY_W-1:0]  hold_cnt;
  logic [POLL_W-1:0]   wait_cnt;
  logic [7:0]          shreg;
  logic [15:0]         meas_value;
  logic [7:0]          meas_crc;
  logic                kind_q;
  logic [DELAY_W-1:0]  cfg_delay;
  logic [POLL_W-1:0]   cfg_timeout;

  // sensor side and traffic knobs
  int  ready_after;
  int  highs_given;
  bit  poll_noise;
  int  stray_start_pct;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  bit  hold_req;
  int  items_sent;
  int  errors;
  int  quiet_cycles;

  hsmm_out_t expected_lines[$];

  humidity_sensor_measure_master_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void model_reset();
    bus_st      = ST_IDLE;
    bit_cnt     = '0;
    hold_cnt    = '0;
    wait_cnt    = '0;
    shreg       = '0;
    meas_value  = '0;
    meas_crc    = '0;
    kind_q      = 1'b0;
    cfg_delay   = DELAY_TICKS_RST;
    cfg_timeout = TIMEOUT_POLLS_RST;
  endfunction

  function automatic void end_of_step(input logic sda);
    case (bus_st)
      ST_RST_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= RESET_PULSES) begin
          bit_cnt = '0;
          bus_st  = ST_TS1;
        end else begin
          bus_st = ST_RST_HI;
        end
      end
      ST_TS8: begin
        shreg   = kind_q ? CMD_HUMID : CMD_TEMP;
        bit_cnt = '0;
        bus_st  = ST_CMD_SET;
      end
      ST_CMD_LO: begin
        shreg   = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        bus_st  = (bit_cnt >= BYTE_BITS) ? ST_CMD_REL : ST_CMD_SET;
      end
      ST_CMD_ACK: begin
        wait_cnt = '0;
        bus_st   = ST_WAIT;
      end
      ST_RX_REL: begin
        bit_cnt = '0;
        bus_st  = ST_RX_HI;
      end
      ST_RX_HI: begin
        shreg  = {shreg[6:0], sda};
        bus_st = ST_RX_LO;
      end
      ST_RX_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= BYTE_BITS) begin
          if (wait_cnt == 0) meas_value[15:8] = shreg;
          else if (wait_cnt == 1) meas_value[7:0] = shreg;
          else meas_crc = shreg;
          bus_st = ST_ACK_SET;
        end else begin
          bus_st = ST_RX_HI;
        end
      end
      ST_RX_END: begin
        wait_cnt = wait_cnt + 1'b1;
        bus_st   = (wait_cnt >= READ_BYTES) ? ST_DONE : ST_RX_REL;
      end
      ST_RST_HI: bus_st = ST_RST_LO;
      ST_RST_B:  bus_st = ST_RST_HI;
      default:   bus_st = seq_st_e'(bus_st + 5'd1);
    endcase
  endfunction

  function automatic hsmm_out_t predict_bus_lines(input hsmm_in_t it);
    hsmm_out_t r;
    int        span;
    logic      ack_lvl;
    span = (cfg_delay == 0) ? 1 : int'(cfg_delay);
    if (bus_st == ST_IDLE) begin
      if (it.start_req) begin
        kind_q   = it.mode;
        bit_cnt  = '0;
        hold_cnt = '0;
        wait_cnt = '0;
        bus_st   = ST_RST_A;
      end
    end else if (bus_st == ST_DONE || bus_st == ST_DONE_TO) begin
      bus_st = ST_IDLE;
    end else if (bus_st == ST_WAIT) begin
      if (!it.sda_in) begin
        wait_cnt = '0;
        bit_cnt  = '0;
        hold_cnt = '0;
        bus_st   = ST_RX_REL;
      end else if (wait_cnt >= cfg_timeout) begin
        bus_st = ST_DONE_TO;
      end else begin
        wait_cnt = wait_cnt + 1'b1;
      end
    end else if (int'(hold_cnt) + 1 < span) begin
      hold_cnt = hold_cnt + 1'b1;
    end else begin
      hold_cnt = '0;
      end_of_step(it.sda_in);
    end

    ack_lvl   = (wait_cnt >= 2);
    r         = '0;
    r.sda_oe  = 1'b1;
    r.sda_out = 1'b1;
    case (bus_st)
      ST_RST_A, ST_RST_B, ST_RST_LO, ST_TS1, ST_TS2, ST_TS8, ST_RX_END: ;
      ST_RST_HI, ST_TS3, ST_TS7: r.scl = 1'b1;
      ST_TS4, ST_TS6: begin
        r.scl     = 1'b1;
        r.sda_out = 1'b0;
      end
      ST_TS5: r.sda_out = 1'b0;
      ST_CMD_SET, ST_CMD_LO: r.sda_out = shreg[7];
      ST_CMD_HI: begin
        r.scl     = 1'b1;
        r.sda_out = shreg[7];
      end
      ST_CMD_ACK, ST_RX_HI: begin
        r.scl    = 1'b1;
        r.sda_oe = 1'b0;
      end
      ST_RX_REL: r.sda_oe = (wait_cnt != 0);
      ST_ACK_SET, ST_ACK_LO: r.sda_out = ack_lvl;
      ST_ACK_HI: begin
        r.scl     = 1'b1;
        r.sda_out = ack_lvl;
      end
      default: r.sda_oe = 1'b0;
    endcase
    r.done_res  = (bus_st == ST_DONE || bus_st == ST_DONE_TO);
    r.busy_res  = (bus_st != ST_IDLE) && !r.done_res;
    r.timed_out = (bus_st == ST_DONE_TO);
    r.value     = (bus_st == ST_DONE) ? meas_value : 16'd0;
    r.checksum  = (bus_st == ST_DONE) ? meas_crc : 8'd0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic hsmm_in_t make_item(input bit want_start);
    hsmm_in_t it;
    it.start_req = ($urandom_range(0, 99) < stray_start_pct);
    it.mode      = 1'($urandom);
    it.sda_in    = 1'($urandom);
    if (bus_st == ST_IDLE) begin
      it.start_req = want_start;
    end else if (bus_st == ST_WAIT && !poll_noise) begin
      it.sda_in = (highs_given < ready_after);
      if (it.sda_in) highs_given++;
    end
    return it;
  endfunction

  task automatic send_tick(input hsmm_in_t it);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_lines.push_back(predict_bus_lines(it));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DELAY_TICKS:   cfg_delay = val[DELAY_W-1:0];
      CFG_TIMEOUT_POLLS: cfg_timeout = val[POLL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(make_item(1'b0));
  endtask

  task automatic run_measurement(input bit kind, input int ready_polls, input bit hold_start);
    hsmm_in_t it;
    ready_after = ready_polls;
    highs_given = 0;
    it          = make_item(1'b1);
    it.mode     = kind;
    send_tick(it);
    while (bus_st != ST_IDLE) begin
      it = make_item(1'b0);
      if (hold_start) it.start_req = 1'b1;
      send_tick(it);
    end
  endtask

  // reset step length checked over the first steps, then the rest runs at one tick
  task automatic test_reset_values();
    hsmm_in_t it;
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    idle_ticks(3);
    ready_after = 2;
    highs_given = 0;
    it          = make_item(1'b1);
    it.mode     = 1'b0;
    send_tick(it);
    idle_ticks(RESET_PROBE_TICKS);
    write_reg(CFG_DELAY_TICKS, 17'd1);
    while (bus_st != ST_IDLE) send_tick(make_item(1'b0));
  endtask

  task automatic test_fast_steps();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    write_reg(CFG_DELAY_TICKS, '0);
    run_measurement(1'b0, 0, 1'b0);
  endtask

  task automatic test_poll_timeout();
    write_reg(CFG_DELAY_TICKS, 17'd1);
    write_reg(CFG_TIMEOUT_POLLS, '0);
    run_measurement(1'b1, 1, 1'b0);
    write_reg(CFG_TIMEOUT_POLLS, 17'd4);
    run_measurement(1'b0, 4, 1'b0);
    run_measurement(1'b1, 5, 1'b0);
  endtask

  task automatic test_start_ignored();
    run_measurement(1'b1, 2, 1'b1);
    idle_ticks(2);
  endtask

  task automatic test_max_regs();
    write_reg(CFG_TIMEOUT_POLLS, 17'h1FFFF);
    run_measurement(1'b1, 60, 1'b0);
    write_reg(CFG_DELAY_TICKS, 17'h0FFFF);
    idle_ticks(20);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_DELAY_TICKS, 17'd1);
    write_reg(CFG_TIMEOUT_POLLS, 17'd20);
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    run_measurement(1'b0, 6, 1'b0);
  endtask

  task automatic test_random_traffic();
    int first;
    int r;
    int d;
    int t;
    int polls;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        d = (r < 2) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : $urandom_range(3, 6);
        write_reg(CFG_DELAY_TICKS, CFG_DAT_W'(d));
        r = $urandom_range(0, 9);
        t = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 12) : $urandom_range(13, 300);
        write_reg(CFG_TIMEOUT_POLLS, CFG_DAT_W'(t));
      end
      tx_gaps_on      = ($urandom_range(0, 9) < 7);
      rx_gaps_on      = ($urandom_range(0, 9) < 7);
      stray_start_pct = $urandom_range(0, 1) ? 15 : 0;
      poll_noise      = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) polls = $urandom_range(0, int'(cfg_timeout));
      else if (r < 8) polls = int'(cfg_timeout) + $urandom_range(0, 1);
      else polls = int'(cfg_timeout) + $urandom_range(1, 6);
      run_measurement(1'($urandom), polls, 1'b0);
      idle_ticks($urandom_range(0, 3));
    end
    poll_noise      = 1'b0;
    stray_start_pct = 0;
  endtask

  initial begin : rx_side
    int n;
    forever begin
      if (hold_req) begin
        n        = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = rx_gaps_on ? pick_gap() : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void cmp_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    hsmm_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_lines.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t result with no request pending: %0h", $time, out_data);
      end else begin
        want = expected_lines.pop_front();
        cmp_field("scl", want.scl, out_data.scl);
        cmp_field("sda_oe", want.sda_oe, out_data.sda_oe);
        cmp_field("sda_out", want.sda_out, out_data.sda_out);
        cmp_field("busy_res", want.busy_res, out_data.busy_res);
        cmp_field("done_res", want.done_res, out_data.done_res);
        cmp_field("timed_out", want.timed_out, out_data.timed_out);
        cmp_field("value", want.value, out_data.value);
        cmp_field("checksum", want.checksum, out_data.checksum);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress, %0d results outstanding", $time,
               expected_lines.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_data         <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    quiet_cycles    <= 0;
    hold_req        = 1'b0;
    tx_gaps_on      = 1'b0;
    rx_gaps_on      = 1'b0;
    poll_noise      = 1'b0;
    stray_start_pct = 0;
    items_sent      = 0;
    errors          = 0;
    ready_after     = 0;
    highs_given     = 0;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_fast_steps();
    test_poll_timeout();
    test_start_ignored();
    test_max_regs();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
